/* rtl/core/prq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the priority ready queue.
// No dependencies; every other file of the block imports this package.
package prq_pkg;

    localparam int ID_W     = 5;
    localparam int PRIO_W   = 5;
    localparam int OP_W     = 2;
    localparam int TSTATE_W = 2;
    localparam int POS_W    = 6;

    localparam logic [OP_W-1:0]     OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0]     OP_REMOVE   = 2'd1;
    localparam logic [TSTATE_W-1:0] TS_ELIGIBLE = 2'd0;

    typedef enum logic [2:0] {
        ST_ADDED,
        ST_DUP,
        ST_BADSTATE,
        ST_FULL,
        ST_REMOVED,
        ST_NOTFOUND,
        ST_MEMBER,
        ST_NOTMEMBER
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_slot;

    typedef struct packed {
        logic prio_gt;
        logic prio_eq;
        logic id_lt;
        logic id_eq;
    } t_cmp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PUT,
        S_UNLINK,
        S_DONE
    } t_state;

endpackage

/* rtl/core/prq_slot_ram.sv */
`timescale 1ns / 1ps
// Slot store of the queue: one write port, one read port, registered read.
// Depends on prq_pkg for the slot type.
module prq_slot_ram #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  logic [AW-1:0]  i_wr_addr,
    input  prq_pkg::t_slot i_wr_data,
    input  logic [AW-1:0]  i_rd_addr,
    output prq_pkg::t_slot o_rd_data
);
    import prq_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/prq_cmp.sv */
`timescale 1ns / 1ps
// Shared compare unit: one stored slot against the request's id and priority.
// Depends on prq_pkg for the slot and compare result types.
module prq_cmp (
    input  prq_pkg::t_slot            i_slot,
    input  logic [prq_pkg::ID_W-1:0]   i_id,
    input  logic [prq_pkg::PRIO_W-1:0] i_prio,
    output prq_pkg::t_cmp             o_cmp
);
    import prq_pkg::*;

    always_comb begin
        o_cmp.prio_gt = i_slot.prio > i_prio;
        o_cmp.prio_eq = i_slot.prio == i_prio;
        o_cmp.id_lt   = i_slot.id < i_id;
        o_cmp.id_eq   = i_slot.id == i_id;
    end

endmodule

/* rtl/core/priority_ready_queue.sv */
`timescale 1ns / 1ps
// Top level of the priority ready queue: sequencer, membership flags, result register.
// Depends on prq_pkg, prq_slot_ram and prq_cmp.
//
//  channel  dir  handshake                 payload
//  s        in   i_s_tvalid / o_s_tready   i_s_tdata, i_s_tuser
//  m        out  o_m_tvalid / i_m_tready   o_m_tdata
//
// Query and refused add/remove pass from accept through S_DECODE and S_DONE to the result.
// Boosted add and remove walk the slot store one slot a cycle through its single read
// port and the shared compare unit: S_SCAN finds the slot, then S_SHIFT_UP or S_SHIFT_DN
// moves the later slots and S_PUT or S_UNLINK finishes; tail append goes S_DECODE, S_PUT, S_DONE.
// Reset clears occupancy and the flags at once; no clearing pass.
// A result waits in the output register; one new beat is taken meanwhile.
module priority_ready_queue #(
    parameter int MAX_THREADS = 32,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // thread_id, priority_req, boosted, thread_state, pad
    input  logic [1:0]  i_s_tuser,  // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // status, position, entry_count, pad
);
    import prq_pkg::*;

    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state                r_state, n_state;
    logic [OP_W-1:0]       r_op;
    logic [ID_W-1:0]       r_id;
    logic [PRIO_W-1:0]     r_prio;
    logic                  r_boost;
    logic [TSTATE_W-1:0]   r_tstate;
    logic [CW-1:0]         r_occ, n_occ;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_chk_idx, n_chk_idx;
    logic                  r_chk_vld, n_chk_vld;
    logic                  r_phase2, n_phase2;
    logic                  r_rd_more, n_rd_more;
    logic [CW-1:0]         r_pos, n_pos;
    t_status               r_status, n_status;
    logic [MAX_THREADS-1:0] r_flags;
    logic                  n_flag_set, n_flag_clr;
    logic                  r_out_valid;
    logic [15:0]           r_out_data;
    logic                  n_out_load;

    logic                  w_accept;
    logic [TW-1:0]         w_fidx;
    logic                  w_id_ok;
    logic                  w_flag;
    logic                  w_full;
    logic                  w_stop;
    logic [CW-1:0]         w_chk_inc;
    logic [CW-1:0]         w_occ_dec;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    t_slot                 w_wr_data;
    logic [AW-1:0]         w_rd_addr;
    t_slot                 w_rd_data;
    t_cmp                  w_cmp;

    prq_slot_ram #(
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    prq_cmp u_cmp (
        .i_slot(w_rd_data),
        .i_id  (r_id),
        .i_prio(r_prio),
        .o_cmp (w_cmp)
    );

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_fidx    = TW'(r_id);
    assign w_id_ok   = int'(r_id) < MAX_THREADS;
    assign w_flag    = w_id_ok && r_flags[w_fidx];
    assign w_full    = r_occ >= CW'(QUEUE_DEPTH);
    assign w_chk_inc = r_chk_idx + CW'(1);
    assign w_occ_dec = r_occ - CW'(1);
    assign w_stop    = (r_op == OP_ADD)
                     ? ((r_phase2 || !w_cmp.prio_gt) && !(w_cmp.prio_eq && w_cmp.id_lt))
                     : w_cmp.id_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_chk_vld   <= 1'b0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_chk_vld <= n_chk_vld;
            if (n_flag_set) begin
                r_flags[w_fidx] <= 1'b1;
            end else if (n_flag_clr) begin
                r_flags[w_fidx] <= 1'b0;
            end
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_s_tuser;
            r_id     <= i_s_tdata[4:0];
            r_prio   <= i_s_tdata[9:5];
            r_boost  <= i_s_tdata[10];
            r_tstate <= i_s_tdata[12:11];
        end
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
        r_phase2  <= n_phase2;
        r_rd_more <= n_rd_more;
        r_pos     <= n_pos;
        r_status  <= n_status;
        if (n_out_load) begin
            r_out_data <= {1'b0, POS_W'(r_occ), POS_W'(r_pos), r_status};
        end
    end

    always_comb begin
        n_state    = r_state;
        n_occ      = r_occ;
        n_idx      = r_idx;
        n_chk_idx  = r_idx;
        n_chk_vld  = 1'b0;
        n_phase2   = r_phase2;
        n_rd_more  = r_rd_more;
        n_pos      = r_pos;
        n_status   = r_status;
        n_flag_set = 1'b0;
        n_flag_clr = 1'b0;
        n_out_load = 1'b0;
        w_rd_addr  = r_idx[AW-1:0];
        w_wr_en    = 1'b0;
        w_wr_addr  = r_pos[AW-1:0];
        w_wr_data  = w_rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_pos    = '0;
                n_idx    = '0;
                n_phase2 = 1'b0;
                n_state  = S_DONE;
                if (r_op == OP_ADD) begin
                    if (r_tstate != TS_ELIGIBLE || !w_id_ok) begin
                        n_status = ST_BADSTATE;
                    end else if (w_flag) begin
                        n_status = ST_DUP;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else if (!r_boost || r_occ == '0) begin
                        n_pos   = r_occ;
                        n_state = S_PUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (r_op == OP_REMOVE) begin
                    if (!w_flag || r_occ == '0) begin
                        n_status = ST_NOTFOUND;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else begin
                    n_status = w_flag ? ST_MEMBER : ST_NOTMEMBER;
                end
            end
            S_SCAN: begin
                if (r_idx < r_occ) begin
                    n_chk_vld = 1'b1;
                    n_idx     = r_idx + CW'(1);
                end
                if (r_chk_vld) begin
                    if (r_op == OP_ADD && !r_phase2 && !w_cmp.prio_gt) begin
                        n_phase2 = 1'b1;
                    end
                    if (w_stop) begin
                        n_chk_vld = 1'b0;
                        n_pos     = r_chk_idx;
                        n_rd_more = 1'b1;
                        if (r_op == OP_ADD) begin
                            n_idx   = w_occ_dec;
                            n_state = S_SHIFT_UP;
                        end else begin
                            n_idx   = w_chk_inc;
                            n_state = (w_chk_inc == r_occ) ? S_UNLINK : S_SHIFT_DN;
                        end
                    end else if (w_chk_inc == r_occ) begin
                        n_chk_vld = 1'b0;
                        if (r_op == OP_ADD) begin
                            n_pos   = r_occ;
                            n_state = S_PUT;
                        end else begin
                            n_pos    = '0;
                            n_status = ST_NOTFOUND;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_SHIFT_UP: begin
                if (r_rd_more) begin
                    n_chk_vld = 1'b1;
                    if (r_idx == r_pos) begin
                        n_rd_more = 1'b0;
                    end else begin
                        n_idx = r_idx - CW'(1);
                    end
                end
                if (r_chk_vld) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_chk_inc[AW-1:0];
                    if (r_chk_idx == r_pos) begin
                        n_chk_vld = 1'b0;
                        n_state   = S_PUT;
                    end
                end
            end
            S_SHIFT_DN: begin
                if (r_rd_more) begin
                    n_chk_vld = 1'b1;
                    if (r_idx == w_occ_dec) begin
                        n_rd_more = 1'b0;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end
                if (r_chk_vld) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = AW'(r_chk_idx - CW'(1));
                    if (r_chk_idx == w_occ_dec) begin
                        n_chk_vld = 1'b0;
                        n_state   = S_UNLINK;
                    end
                end
            end
            S_PUT: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_pos[AW-1:0];
                w_wr_data  = '{id: r_id, prio: r_prio};
                n_occ      = r_occ + CW'(1);
                n_flag_set = 1'b1;
                n_status   = ST_ADDED;
                n_state    = S_DONE;
            end
            S_UNLINK: begin
                n_occ      = w_occ_dec;
                n_flag_clr = 1'b1;
                n_status   = ST_REMOVED;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> $countones(r_flags) == int'(r_occ))
        else $error("membership flags disagree with occupancy");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT_UP || r_state == S_SHIFT_DN)
        |-> r_occ != '0)
        else $error("slot walk on an empty queue");

    a_put_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PUT |-> (r_pos <= r_occ && !w_full))
        else $error("insert slot beyond occupancy");
`endif

endmodule

/* verif/priority_ready_queue_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for priority_ready_queue: directed, fill/drain and random request beats.
// Predicts each result from its own copy of the queue; depends on prq_pkg and the block only.
module priority_ready_queue_test;
    import prq_pkg::*;

    localparam int          DEPTH       = 32;
    localparam int          THREADS     = 32;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          TAIL_CYCLES = 80;
    localparam logic [1:0]  OP_QUERY    = 2'd2;
    localparam logic [1:0]  OP_SPARE    = 2'd3;
    localparam logic [1:0]  TS_RUNNING  = 2'd1;
    localparam logic [1:0]  TS_EXITED   = 2'd2;
    localparam logic [1:0]  TS_SPARE    = 2'd3;

    typedef struct packed {
        t_status    status;
        logic [5:0] position;
        logic [5:0] count;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;  // thread_id, priority_req, boosted, thread_state, pad
    logic [1:0]  i_s_tuser;  // op
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;  // status, position, entry_count, pad

    priority_ready_queue #(
        .MAX_THREADS(THREADS),
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    logic [4:0]  shadow_ids [DEPTH];
    logic [4:0]  shadow_prio [DEPTH];
    bit          shadow_flag [THREADS];
    int          shadow_count;

    t_outcome    pending_results[$];
    t_outcome    want;
    t_outcome    got;
    bit          calm;
    int          cycles = 0;
    int          mismatches = 0;
    int          beats_sent;
    int          beats_checked = 0;
    int          peak_count;
    int          leftover;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_outcome queue_predict(input logic [1:0] op, input logic [4:0] id,
                                               input logic [4:0] prio, input logic boost,
                                               input logic [1:0] ts);
        t_outcome r;
        int       p;
        int       hit;
        r.status   = ST_NOTMEMBER;
        r.position = '0;
        p          = 0;
        hit        = -1;
        if (op == OP_ADD) begin
            if (ts != TS_ELIGIBLE) begin
                r.status = ST_BADSTATE;
            end else if (shadow_flag[id]) begin
                r.status = ST_DUP;
            end else if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                if (boost) begin
                    while (p < shadow_count && shadow_prio[p] > prio) p++;
                    while (p < shadow_count && shadow_prio[p] == prio && shadow_ids[p] < id) p++;
                end else begin
                    p = shadow_count;
                end
                for (int k = shadow_count; k > p; k--) begin
                    shadow_ids[k]  = shadow_ids[k-1];
                    shadow_prio[k] = shadow_prio[k-1];
                end
                shadow_ids[p]   = id;
                shadow_prio[p]  = prio;
                shadow_count++;
                shadow_flag[id] = 1'b1;
                r.status        = ST_ADDED;
                r.position      = 6'(p);
            end
        end else if (op == OP_REMOVE) begin
            r.status = ST_NOTFOUND;
            for (int k = 0; k < shadow_count; k++)
                if (hit < 0 && shadow_ids[k] == id) hit = k;
            if (hit >= 0) begin
                for (int k = hit; k + 1 < shadow_count; k++) begin
                    shadow_ids[k]  = shadow_ids[k+1];
                    shadow_prio[k] = shadow_prio[k+1];
                end
                shadow_count--;
                shadow_flag[id] = 1'b0;
                r.status        = ST_REMOVED;
                r.position      = 6'(hit);
            end
        end else begin
            r.status = shadow_flag[id] ? ST_MEMBER : ST_NOTMEMBER;
        end
        r.count = 6'(shadow_count);
        if (shadow_count > peak_count) peak_count = shadow_count;
        return r;
    endfunction

    // Entered and left at a falling edge; valid stays high when no gap is drawn.
    task automatic send_request(input logic [1:0] op, input logic [4:0] id,
                                input logic [4:0] prio, input logic boost,
                                input logic [1:0] ts);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = {3'b000, ts, boost, prio, id};
        i_s_tuser  = op;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(queue_predict(op, id, prio, boost, ts));
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        calm = 1'b0;
        send_request(OP_QUERY,  5'd0,  5'd0,  1'b0, TS_ELIGIBLE);
        send_request(OP_REMOVE, 5'd31, 5'd0,  1'b0, TS_ELIGIBLE);
        send_request(OP_ADD,    5'd7,  5'd9,  1'b0, TS_RUNNING);
        send_request(OP_ADD,    5'd7,  5'd9,  1'b1, TS_EXITED);
        send_request(OP_ADD,    5'd7,  5'd31, 1'b1, TS_SPARE);
        send_request(OP_ADD,    5'd0,  5'd0,  1'b0, TS_ELIGIBLE);
        send_request(OP_ADD,    5'd31, 5'd31, 1'b1, TS_ELIGIBLE);
        send_request(OP_ADD,    5'd5,  5'd31, 1'b1, TS_ELIGIBLE);
        send_request(OP_ADD,    5'd10, 5'd31, 1'b1, TS_ELIGIBLE);
        send_request(OP_ADD,    5'd20, 5'd0,  1'b1, TS_ELIGIBLE);
        send_request(OP_ADD,    5'd2,  5'd16, 1'b0, TS_ELIGIBLE);
        send_request(OP_ADD,    5'd5,  5'd3,  1'b1, TS_ELIGIBLE);
        send_request(OP_ADD,    5'd5,  5'd3,  1'b1, TS_RUNNING);
        send_request(OP_QUERY,  5'd5,  5'd0,  1'b0, TS_ELIGIBLE);
        send_request(OP_SPARE,  5'd10, 5'd31, 1'b1, TS_SPARE);
        send_request(OP_SPARE,  5'd9,  5'd0,  1'b0, TS_ELIGIBLE);
        send_request(OP_REMOVE, 5'd31, 5'd0,  1'b0, TS_ELIGIBLE);
        send_request(OP_REMOVE, 5'd31, 5'd0,  1'b0, TS_ELIGIBLE);
        send_request(OP_REMOVE, 5'd5,  5'd0,  1'b0, TS_ELIGIBLE);
        send_request(OP_REMOVE, 5'd2,  5'd0,  1'b0, TS_ELIGIBLE);
        send_request(OP_QUERY,  5'd31, 5'd0,  1'b0, TS_ELIGIBLE);
        send_request(OP_ADD,    5'd31, 5'd0,  1'b1, TS_ELIGIBLE);
    endtask

    // Fill to capacity in shuffled id order, try a duplicate, then drain to empty.
    task automatic test_fill_and_drain();
        int order [THREADS];
        int j;
        int tmp;
        calm = 1'b0;
        while (shadow_count > 0)
            send_request(OP_REMOVE, shadow_ids[0], 5'd0, 1'b0, TS_ELIGIBLE);
        for (int k = 0; k < THREADS; k++) order[k] = k;
        for (int k = THREADS - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        calm = 1'b1;
        for (int k = 0; k < THREADS; k++)
            send_request(OP_ADD, 5'(order[k]), 5'($urandom_range(0, 31)),
                         1'($urandom_range(0, 3) != 0), TS_ELIGIBLE);
        calm = 1'b0;
        send_request(OP_ADD, 5'($urandom_range(0, 31)), 5'd31, 1'b1, TS_ELIGIBLE);
        send_request(OP_QUERY, 5'd31, 5'd0, 1'b0, TS_ELIGIBLE);
        send_request(OP_REMOVE, shadow_ids[DEPTH-1], 5'd0, 1'b0, TS_ELIGIBLE);
        while (shadow_count > 0)
            send_request(OP_REMOVE, shadow_ids[$urandom_range(0, shadow_count - 1)],
                         5'd0, 1'b0, TS_ELIGIBLE);
        send_request(OP_REMOVE, 5'd0, 5'd0, 1'b0, TS_ELIGIBLE);
    endtask

    // Mostly sensible traffic steering towards a moving occupancy target, plus noise.
    task automatic test_random_mix(input int n);
        int         target;
        int         pick;
        logic [4:0] id;
        logic [4:0] prio;
        for (int i = 0; i < n; i++) begin
            if (i % 80 == 0) begin
                pick   = $urandom_range(0, 5);
                target = (pick == 0) ? 0 : (pick == 1) ? DEPTH : $urandom_range(1, DEPTH);
            end
            calm = ((i / 125) % 4 == 3);
            pick = $urandom_range(0, 99);
            prio = $urandom_range(0, 1) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(12, 14));
            if (pick < 80) begin
                if (shadow_count < target) begin
                    do id = 5'($urandom_range(0, 31)); while (shadow_flag[id]);
                    send_request(OP_ADD, id, prio, 1'($urandom_range(0, 3) != 0), TS_ELIGIBLE);
                end else if (shadow_count > target) begin
                    id = shadow_ids[$urandom_range(0, shadow_count - 1)];
                    send_request(OP_REMOVE, id, prio, 1'($urandom_range(0, 1)),
                                 TS_ELIGIBLE);
                end else begin
                    send_request(OP_QUERY, 5'($urandom_range(0, 31)), prio,
                                 1'($urandom_range(0, 1)), TS_ELIGIBLE);
                end
            end else begin
                send_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), prio,
                             1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        calm         = 1'b0;
        shadow_count = 0;
        peak_count   = 0;
        beats_sent   = 0;
        for (int k = 0; k < DEPTH; k++) begin
            shadow_ids[k]  = '0;
            shadow_prio[k] = '0;
        end
        for (int k = 0; k < THREADS; k++) shadow_flag[k] = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_fill_and_drain();
        test_random_mix(1450);

        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        leftover = pending_results.size();
        $display("covered %0d requests (adds, removes, queries, refusals), %0d results checked",
                 beats_sent, beats_checked);
        $display("peak occupancy %0d of %0d, %0d mismatches", peak_count, DEPTH, mismatches);
        if (mismatches == 0 && leftover == 0) begin
            $display("priority_ready_queue_test: done, clean");
        end else begin
            $display("priority_ready_queue_test: done, errors");
        end
        $finish;
    end

    // Result sink: draw a stall before each beat, hold ready until the beat is taken.
    initial begin
        int stall;
        i_m_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("priority_ready_queue_test: done, errors");
            $finish;
        end else if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status   = t_status'(o_m_tdata[2:0]);
            got.position = o_m_tdata[8:3];
            got.count    = o_m_tdata[14:9];
            beats_checked++;
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result beat: status %0d position %0d count %0d",
                             got.status, got.position, got.count);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (want != got) begin
                    if (mismatches < 10)
                        $display("result %0d: status %0d/%0d pos %0d/%0d count %0d/%0d (exp/act)",
                                 beats_checked, want.status, got.status,
                                 want.position, got.position, want.count, got.count);
                    mismatches++;
                end
            end
        end
    end

endmodule
